/* rtl/core/per_sensor_median3_filter_macros.svh */
// Assertion macros used by the checker file of the median-of-three filter.
// No dependencies; included by bare file name.
`ifndef PER_SENSOR_MEDIAN3_FILTER_MACROS_SVH
`define PER_SENSOR_MEDIAN3_FILTER_MACROS_SVH

// General property check, clocked on rising clk, off while reset is low.
`define PSM3_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication in the same cycle.
`define PSM3_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication in the next cycle.
`define PSM3_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/psm3_pkg.sv */
// Shared types and constants of the per-sensor median-of-three filter.
// No dependencies; imported by the filter, the compare-swap unit and the testbench.
package psm3_pkg;

	localparam int ENTRIES      = 8;
	localparam int IDX_W        = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int RING_DEPTH   = 3;
	localparam int POS_W        = $clog2(RING_DEPTH + 1);
	localparam int RING_ENTRIES = ENTRIES * RING_DEPTH;
	localparam int RING_IDX_W   = $clog2(RING_ENTRIES);

	localparam int ADDR_W = 48;
	localparam int TEMP_W = 15;
	localparam int HUM_W  = 14;
	localparam int CO2_W  = 16;

	// one sample holds three channel lanes, all 16 bits wide
	localparam int LANE_W    = 16;
	localparam int NUM_LANES = 3;
	localparam int LANE_TEMP = 0;
	localparam int LANE_HUM  = 1;
	localparam int LANE_CO2  = 2;
	localparam logic [NUM_LANES-1:0] LANE_SIGNED = 3'b001;

	typedef logic [LANE_W-1:0] lane_t;
	typedef lane_t [NUM_LANES-1:0] sample_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_UPDATE,
		ST_LOAD,
		ST_SORT,
		ST_REPLY
	} state_t;

endpackage

/* rtl/core/psm3_cmpswap.sv */
// Shared compare-and-swap unit: orders two samples lane by lane.
// Depends on psm3_pkg (sample_t, lane signedness).
module psm3_cmpswap (
	input  psm3_pkg::sample_t x,
	input  psm3_pkg::sample_t y,
	output psm3_pkg::sample_t lo,
	output psm3_pkg::sample_t hi
);
	import psm3_pkg::*;

	always_comb begin
		logic gt;
		for (int l = 0; l < NUM_LANES; l++) begin
			if (LANE_SIGNED[l]) begin
				gt = $signed(x[l]) > $signed(y[l]);
			end else begin
				gt = x[l] > y[l];
			end
			lo[l] = gt ? y[l] : x[l];
			hi[l] = gt ? x[l] : y[l];
		end
	end

endmodule

/* rtl/core/per_sensor_median3_filter.sv */
// Per-sensor median-of-three filter: address table, sample rings, sequencer.
// Depends on psm3_pkg and psm3_cmpswap.
//
// Usage: a reading is taken when start is high and busy is low; its fields
// must be on the input ports at that edge. Exactly one result comes back per
// reading, on the output ports for one cycle while done is high. The
// receiver cannot stall; done is a one-cycle strobe and nothing waits.
// An unparsed reading goes straight to its reply. A parsed one searches the
// table; if no entry matches and none is free it replies with table_full,
// else it writes its sample into the ring and replies unfiltered while fewer
// than three samples are held, or loads and sorts them before the reply.
// The search walks the table one entry a cycle through one address compare;
// the median runs three loads over the single ring read port and then
// three passes through the shared compare-swap unit. busy stays high for the
// whole item, so the next reading can be taken in the cycle done is shown.
// Reset clears every slot valid bit, ring, write position and fill count;
// the first reading may be taken in the first cycle after reset is released.
module per_sensor_median3_filter (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                parsed,
	input  logic [psm3_pkg::ADDR_W-1:0]         device_address,
	input  logic                                has_co2,
	input  logic signed [psm3_pkg::TEMP_W-1:0]  temperature,
	input  logic [psm3_pkg::HUM_W-1:0]          humidity,
	input  logic [psm3_pkg::CO2_W-1:0]          co2_level,
	output logic                                done,
	output logic signed [psm3_pkg::TEMP_W-1:0]  temperature_out,
	output logic [psm3_pkg::HUM_W-1:0]          humidity_out,
	output logic [psm3_pkg::CO2_W-1:0]          co2_out,
	output logic                                filtered,
	output logic                                table_full
);
	import psm3_pkg::*;

	localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(ENTRIES - 1);
	localparam logic [1:0]       STEP_LAST = 2'(RING_DEPTH - 1);

	state_t state_q, state_d;

	// latched reading
	logic              parsed_q, co2_sel_q;
	logic [ADDR_W-1:0] addr_q;
	logic [TEMP_W-1:0] temp_in_q;
	logic [HUM_W-1:0]  hum_in_q;
	logic [CO2_W-1:0]  co2_in_q;

	// table and history
	logic [ENTRIES-1:0] slot_valid_q;
	logic [ADDR_W-1:0]  slot_addr_q [ENTRIES];
	sample_t            ring_q      [RING_ENTRIES];
	logic [POS_W-1:0]   wpos_q      [ENTRIES];
	logic [POS_W-1:0]   fill_q      [ENTRIES];

	// sequencer
	logic [IDX_W-1:0] idx_q, free_idx_q, ent_q;
	logic             free_found_q;
	logic [1:0]       step_q;
	logic             filt_q, full_q;
	sample_t          samp_q [RING_DEPTH];

	// result registers
	logic              done_q, filt_out_q, full_out_q;
	logic [TEMP_W-1:0] temp_out_q;
	logic [HUM_W-1:0]  hum_out_q;
	logic [CO2_W-1:0]  co2_out_q;

	logic                  accept, cur_hit, cur_free, idx_last, claim_ok;
	logic [IDX_W-1:0]      claim_idx;
	logic [RING_IDX_W-1:0] ring_base, wr_idx, rd_idx;
	logic [POS_W-1:0]      pos_cur, pos_next, fill_cur, fill_next;
	logic                  will_filter;
	sample_t               new_sample, cs_x, cs_y, cs_lo, cs_hi;

	assign accept    = start && !busy;
	assign cur_hit   = slot_valid_q[idx_q] && (slot_addr_q[idx_q] == addr_q);
	assign cur_free  = !slot_valid_q[idx_q];
	assign idx_last  = idx_q == IDX_LAST;
	assign claim_ok  = free_found_q || cur_free;
	assign claim_idx = free_found_q ? free_idx_q : idx_q;

	assign ring_base = RING_IDX_W'(ent_q) * RING_IDX_W'(RING_DEPTH);
	assign pos_cur   = (wpos_q[ent_q] >= POS_W'(RING_DEPTH)) ? '0 : wpos_q[ent_q];
	assign pos_next  = (pos_cur == POS_W'(RING_DEPTH - 1)) ? '0 : pos_cur + POS_W'(1);
	assign wr_idx    = ring_base + RING_IDX_W'(pos_cur);
	assign rd_idx    = ring_base + RING_IDX_W'(step_q);
	assign fill_cur  = fill_q[ent_q];
	assign fill_next = (fill_cur < POS_W'(RING_DEPTH)) ? fill_cur + POS_W'(1) : fill_cur;
	assign will_filter = fill_next >= POS_W'(RING_DEPTH);

	always_comb begin
		new_sample[LANE_TEMP] = {temp_in_q[TEMP_W-1], temp_in_q};
		new_sample[LANE_HUM]  = {{(LANE_W - HUM_W){1'b0}}, hum_in_q};
		// a non-CO2 reading leaves the CO2 lane as it was
		new_sample[LANE_CO2]  = co2_sel_q ? co2_in_q : ring_q[wr_idx][LANE_CO2];
	end

	// sort network on the shared unit: (0,1), (1,2), (0,1); median ends in slot 1
	assign cs_x = (step_q == 2'd1) ? samp_q[1] : samp_q[0];
	assign cs_y = (step_q == 2'd1) ? samp_q[2] : samp_q[1];

	psm3_cmpswap u_cmpswap (
		.x  (cs_x),
		.y  (cs_y),
		.lo (cs_lo),
		.hi (cs_hi)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_d = parsed ? ST_SEARCH : ST_REPLY;
			end
			ST_SEARCH: begin
				if (cur_hit) begin
					state_d = ST_UPDATE;
				end else if (idx_last) begin
					state_d = claim_ok ? ST_UPDATE : ST_REPLY;
				end
			end
			ST_UPDATE: state_d = will_filter ? ST_LOAD : ST_REPLY;
			ST_LOAD:   if (step_q == STEP_LAST) state_d = ST_SORT;
			ST_SORT:   if (step_q == STEP_LAST) state_d = ST_REPLY;
			ST_REPLY:  state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	assign busy = state_q != ST_IDLE;

	// control and history state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
			for (int i = 0; i < RING_ENTRIES; i++) ring_q[i] <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				wpos_q[i] <= '0;
				fill_q[i] <= '0;
			end
			idx_q        <= '0;
			free_idx_q   <= '0;
			ent_q        <= '0;
			free_found_q <= 1'b0;
			step_q       <= '0;
			filt_q       <= 1'b0;
			full_q       <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						idx_q        <= '0;
						free_found_q <= 1'b0;
						step_q       <= '0;
						filt_q       <= 1'b0;
						full_q       <= 1'b0;
					end
				end
				ST_SEARCH: begin
					if (cur_hit) begin
						ent_q <= idx_q;
					end else if (idx_last) begin
						if (claim_ok) begin
							ent_q                   <= claim_idx;
							slot_valid_q[claim_idx] <= 1'b1;
						end else begin
							full_q <= 1'b1;
						end
					end else begin
						if (cur_free && !free_found_q) begin
							free_found_q <= 1'b1;
							free_idx_q   <= idx_q;
						end
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				ST_UPDATE: begin
					ring_q[wr_idx] <= new_sample;
					wpos_q[ent_q]  <= pos_next;
					fill_q[ent_q]  <= fill_next;
					filt_q         <= will_filter;
					step_q         <= '0;
				end
				ST_LOAD, ST_SORT: begin
					step_q <= (step_q == STEP_LAST) ? 2'd0 : step_q + 2'd1;
				end
				ST_REPLY: done_q <= 1'b1;
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			parsed_q  <= parsed;
			addr_q    <= device_address;
			co2_sel_q <= has_co2;
			temp_in_q <= temperature;
			hum_in_q  <= humidity;
			co2_in_q  <= co2_level;
		end
		if (state_q == ST_SEARCH && !cur_hit && idx_last && claim_ok) begin
			slot_addr_q[claim_idx] <= addr_q;
		end
		if (state_q == ST_LOAD) begin
			samp_q[step_q] <= ring_q[rd_idx];
		end
		if (state_q == ST_SORT) begin
			if (step_q == 2'd1) begin
				samp_q[1] <= cs_lo;
				samp_q[2] <= cs_hi;
			end else begin
				samp_q[0] <= cs_lo;
				samp_q[1] <= cs_hi;
			end
		end
		if (state_q == ST_REPLY) begin
			temp_out_q <= filt_q ? samp_q[1][LANE_TEMP][TEMP_W-1:0] : temp_in_q;
			hum_out_q  <= filt_q ? samp_q[1][LANE_HUM][HUM_W-1:0] : hum_in_q;
			co2_out_q  <= (filt_q && co2_sel_q) ? samp_q[1][LANE_CO2][CO2_W-1:0] : co2_in_q;
			filt_out_q <= filt_q && parsed_q;
			full_out_q <= full_q && parsed_q;
		end
	end

	assign done            = done_q;
	assign temperature_out = $signed(temp_out_q);
	assign humidity_out    = hum_out_q;
	assign co2_out         = co2_out_q;
	assign filtered        = filt_out_q;
	assign table_full      = full_out_q;

endmodule

/* rtl/core/psm3_checker.sv */
// Port-level checks on the handshake and result flags of the filter.
// Depends on per_sensor_median3_filter_macros.svh; bound to the top level.
`include "per_sensor_median3_filter_macros.svh"

module psm3_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic filtered,
	input logic table_full
);

	// a result only shows once the block has gone idle again
	`PSM3_ASSERT_IMP(a_done_idle, clk, arst_n, done, !busy, "result shown while busy")
	`PSM3_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy, "beat taken, not busy")
	`PSM3_ASSERT_NEXT(a_done_single, clk, arst_n, done, !done, "done held over two cycles")
	`PSM3_ASSERT_IMP(a_flags, clk, arst_n, done, !(filtered && table_full), "filtered and full")
	// every item ends in exactly one result
	`PSM3_ASSERT(a_end_result, clk, arst_n, $fell(busy) |-> done, "item ended with no result")

endmodule

bind per_sensor_median3_filter psm3_checker u_psm3_checker (.*);

/* test/per_sensor_median3_filter_test.sv */
// Self-checking testbench for the per-sensor median-of-three filter.
// Depends on psm3_pkg and the per_sensor_median3_filter RTL; needs nothing else.
// A queue-fed driver and a done-strobe monitor check every result against a built-in predictor.
`timescale 1ns / 100ps

module per_sensor_median3_filter_test;
	import psm3_pkg::*;

	localparam int RANDOM_READINGS = 1500;
	localparam int CYCLE_LIMIT     = 400000;
	localparam int TAIL_CYCLES     = 40;
	localparam logic [ADDR_W-1:0] OVERFLOW_ADDR = 48'h5A5A_5A5A_5A5A;

	typedef struct {
		logic                       parsed;
		logic [ADDR_W-1:0]          addr;
		logic                       has_co2;
		logic signed [TEMP_W-1:0]   temp;
		logic [HUM_W-1:0]           hum;
		logic [CO2_W-1:0]           co2;
		bit                         drain;   // hold this beat until nothing is outstanding
		int                         gap;     // idle cycles after this beat
	} reading_t;

	typedef struct {
		logic signed [TEMP_W-1:0]   temp;
		logic [HUM_W-1:0]           hum;
		logic [CO2_W-1:0]           co2;
		logic                       filt;
		logic                       full;
	} filter_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic parsed = 1'b0;
	logic [ADDR_W-1:0] device_address = '0;
	logic has_co2 = 1'b0;
	logic signed [TEMP_W-1:0] temperature = '0;
	logic [HUM_W-1:0] humidity = '0;
	logic [CO2_W-1:0] co2_level = '0;
	logic done;
	logic signed [TEMP_W-1:0] temperature_out;
	logic [HUM_W-1:0] humidity_out;
	logic [CO2_W-1:0] co2_out;
	logic filtered;
	logic table_full;

	reading_t       pending_readings[$];
	filter_result_t expected_results[$];
	reading_t       driven_reading;
	int             gap_left = 0;
	int             err_count = 0;
	int             cycle_count = 0;
	logic [ADDR_W-1:0] sensor_pool[8];

	// predictor copy of the history table
	bit                       slot_used[ENTRIES];
	logic [ADDR_W-1:0]        slot_addr[ENTRIES];
	logic signed [TEMP_W-1:0] temp_hist[ENTRIES][RING_DEPTH];
	logic [HUM_W-1:0]         hum_hist[ENTRIES][RING_DEPTH];
	logic [CO2_W-1:0]         co2_hist[ENTRIES][RING_DEPTH];
	int                       ring_pos[ENTRIES];
	int                       ring_fill[ENTRIES];

	always #1 clk = ~clk;

	per_sensor_median3_filter u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.parsed          (parsed),
		.device_address  (device_address),
		.has_co2         (has_co2),
		.temperature     (temperature),
		.humidity        (humidity),
		.co2_level       (co2_level),
		.done            (done),
		.temperature_out (temperature_out),
		.humidity_out    (humidity_out),
		.co2_out         (co2_out),
		.filtered        (filtered),
		.table_full      (table_full)
	);

	function automatic logic signed [TEMP_W-1:0] median_temp(logic signed [TEMP_W-1:0] a,
			logic signed [TEMP_W-1:0] b, logic signed [TEMP_W-1:0] c);
		logic signed [TEMP_W-1:0] lo, hi;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		return (c < lo) ? lo : ((c > hi) ? hi : c);
	endfunction

	function automatic logic [CO2_W-1:0] median_unsigned(logic [CO2_W-1:0] a,
			logic [CO2_W-1:0] b, logic [CO2_W-1:0] c);
		logic [CO2_W-1:0] lo, hi;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		return (c < lo) ? lo : ((c > hi) ? hi : c);
	endfunction

	// Updates the table copy with one accepted reading and returns its result.
	function automatic filter_result_t predict_filter(reading_t rd);
		filter_result_t res;
		int slot;
		int p;
		res.temp = rd.temp;
		res.hum  = rd.hum;
		res.co2  = rd.co2;
		res.filt = 1'b0;
		res.full = 1'b0;
		slot = -1;
		if (rd.parsed) begin
			for (int i = 0; i < ENTRIES; i++)
				if (slot < 0 && slot_used[i] && slot_addr[i] == rd.addr)
					slot = i;
			for (int i = 0; i < ENTRIES; i++)
				if (slot < 0 && !slot_used[i]) begin
					slot_used[i] = 1'b1;
					slot_addr[i] = rd.addr;
					slot = i;
				end
			if (slot < 0) begin
				res.full = 1'b1;
			end else begin
				p = ring_pos[slot];
				temp_hist[slot][p] = rd.temp;
				hum_hist[slot][p]  = rd.hum;
				if (rd.has_co2)
					co2_hist[slot][p] = rd.co2;
				ring_pos[slot] = (p == RING_DEPTH - 1) ? 0 : p + 1;
				if (ring_fill[slot] < RING_DEPTH)
					ring_fill[slot]++;
				if (ring_fill[slot] == RING_DEPTH) begin
					res.filt = 1'b1;
					res.temp = median_temp(temp_hist[slot][0], temp_hist[slot][1],
						temp_hist[slot][2]);
					res.hum = HUM_W'(median_unsigned(CO2_W'(hum_hist[slot][0]),
						CO2_W'(hum_hist[slot][1]), CO2_W'(hum_hist[slot][2])));
					if (rd.has_co2)
						res.co2 = median_unsigned(co2_hist[slot][0], co2_hist[slot][1],
							co2_hist[slot][2]);
				end
			end
		end
		return res;
	endfunction

	task automatic report_mismatch(string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		err_count++;
	endtask

	task automatic add_reading(logic p, logic [ADDR_W-1:0] a, logic c2, int t, int h, int c,
			bit drain, int gap);
		reading_t rd;
		rd.parsed  = p;
		rd.addr    = a;
		rd.has_co2 = c2;
		rd.temp    = TEMP_W'(t);
		rd.hum     = HUM_W'(h);
		rd.co2     = CO2_W'(c);
		rd.drain   = drain;
		rd.gap     = gap;
		pending_readings.push_back(rd);
	endtask

	function automatic int pick_temp();
		int r;
		r = $urandom_range(99);
		if (r < 80) return int'($urandom_range(12500)) - 4000;
		if (r < 90) return int'($urandom_range(32767)) - 16384;
		return int'($urandom_range(2)) * 5 - 5;
	endfunction

	function automatic int pick_hum();
		int r;
		r = $urandom_range(99);
		if (r < 80) return $urandom_range(10000);
		if (r < 90) return $urandom_range(16383);
		return $urandom_range(2) * 50;
	endfunction

	function automatic int pick_co2();
		int r;
		r = $urandom_range(99);
		if (r < 85) return $urandom_range(65535);
		return 400 + $urandom_range(2);
	endfunction

	function automatic logic [ADDR_W-1:0] random_addr();
		return ADDR_W'({$urandom, $urandom});
	endfunction

	// driver: presents one beat at a time from the pending queue
	always @(posedge clk) begin : drive_readings
		reading_t rd;
		logic     go;
		if (arst_n) begin
			if (start && !busy)
				expected_results.push_back(predict_filter(driven_reading));
			go = 1'b0;
			if (start && busy) begin
				go = 1'b1;
			end else if (gap_left > 0) begin
				gap_left--;
			end else if (pending_readings.size() > 0 &&
					!(pending_readings[0].drain && expected_results.size() != 0)) begin
				rd = pending_readings.pop_front();
				driven_reading <= rd;
				parsed         <= rd.parsed;
				device_address <= rd.addr;
				has_co2        <= rd.has_co2;
				temperature    <= rd.temp;
				humidity       <= rd.hum;
				co2_level      <= rd.co2;
				gap_left       = rd.gap;
				go = 1'b1;
			end
			start <= go;
		end
	end

	// monitor: every done beat must match the oldest expectation
	always @(posedge clk) begin : check_results
		filter_result_t exp_res;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result beat with nothing outstanding");
			end else begin
				exp_res = expected_results.pop_front();
				if (temperature_out !== exp_res.temp)
					report_mismatch($sformatf("temperature_out %0d, want %0d",
						temperature_out, exp_res.temp));
				if (humidity_out !== exp_res.hum)
					report_mismatch($sformatf("humidity_out %0d, want %0d",
						humidity_out, exp_res.hum));
				if (co2_out !== exp_res.co2)
					report_mismatch($sformatf("co2_out %0d, want %0d", co2_out, exp_res.co2));
				if (filtered !== exp_res.filt)
					report_mismatch($sformatf("filtered %b, want %b", filtered, exp_res.filt));
				if (table_full !== exp_res.full)
					report_mismatch($sformatf("table_full %b, want %b",
						table_full, exp_res.full));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("per_sensor_median3_filter_test: done, errors");
			$finish;
		end
	end

	initial begin
		logic [ADDR_W-1:0] a;
		bit                clash;
		bit                burst;
		int                k, r, gap;
		logic              c2;

		for (int i = 0; i < ENTRIES; i++) begin
			slot_used[i] = 1'b0;
			ring_pos[i]  = 0;
			ring_fill[i] = 0;
			for (int j = 0; j < RING_DEPTH; j++) begin
				temp_hist[i][j] = '0;
				hum_hist[i][j]  = '0;
				co2_hist[i][j]  = '0;
			end
		end

		sensor_pool[0] = '0;
		sensor_pool[1] = '1;
		for (int i = 2; i < 8; i++) begin
			do begin
				a = random_addr();
				clash = (a == OVERFLOW_ADDR);
				for (int j = 0; j < i; j++)
					if (sensor_pool[j] == a)
						clash = 1'b1;
			end while (clash);
			sensor_pool[i] = a;
		end

		// unparsed beats pass through untouched
		add_reading(1'b0, '1, 1'b1, -16384, 16383, 65535, 1'b0, 0);
		add_reading(1'b0, '0, 1'b0, 16383, 0, 0, 1'b0, 2);
		// CO2 sensor fills its ring, third beat gives medians
		add_reading(1'b1, sensor_pool[0], 1'b1, -4000, 0, 0, 1'b0, 0);
		add_reading(1'b1, sensor_pool[0], 1'b1, 8500, 10000, 65535, 1'b0, 0);
		add_reading(1'b1, sensor_pool[0], 1'b1, 100, 5000, 400, 1'b0, 0);
		// non-CO2 beat on a CO2 entry: co2 stays raw
		add_reading(1'b1, sensor_pool[0], 1'b0, -16384, 16383, 1234, 1'b0, 0);
		add_reading(1'b1, sensor_pool[0], 1'b1, 16383, 0, 65535, 1'b1, 0);
		// CO2 beat on an entry that only held non-CO2 samples
		add_reading(1'b1, sensor_pool[1], 1'b0, 7, 7, 7, 1'b0, 0);
		add_reading(1'b1, sensor_pool[1], 1'b0, 7, 7, 7, 1'b0, 0);
		add_reading(1'b1, sensor_pool[1], 1'b1, -1, 3, 999, 1'b0, 0);
		add_reading(1'b1, sensor_pool[1], 1'b1, -1, 3, 999, 1'b0, 1);
		// claim the remaining slots, then overflow the table
		for (int i = 2; i < 8; i++)
			add_reading(1'b1, sensor_pool[i], i[0], pick_temp(), pick_hum(), pick_co2(),
				1'b0, 0);
		add_reading(1'b1, OVERFLOW_ADDR, 1'b1, 8500, 10000, 65535, 1'b1, 0);
		add_reading(1'b0, OVERFLOW_ADDR, 1'b0, -4000, 0, 0, 1'b0, 0);
		add_reading(1'b1, sensor_pool[7], 1'b1, 0, 0, 0, 1'b0, 0);

		burst = 1'b0;
		for (int n = 0; n < RANDOM_READINGS; n++) begin
			if (n % 50 == 0)
				burst = ($urandom_range(3) == 0);
			r = $urandom_range(99);
			if (burst || r < 50)
				gap = 0;
			else if (r < 85)
				gap = $urandom_range(3, 1);
			else
				gap = $urandom_range(40, 8);
			k = $urandom_range(7);
			// sensors keep their kind most of the time
			c2 = ($urandom_range(9) == 0) ? ~k[0] : k[0];
			if ($urandom_range(99) < 85)
				a = sensor_pool[k];
			else
				a = random_addr();
			add_reading(($urandom_range(9) != 0), a, c2, pick_temp(), pick_hum(), pick_co2(),
				(n == 0) || ($urandom_range(99) == 0), gap);
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_readings.size() != 0 || start || expected_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (err_count == 0)
			$display("per_sensor_median3_filter_test: done, clean");
		else
			$display("per_sensor_median3_filter_test: done, errors");
		$finish;
	end

endmodule
